@@ rtl/core/snfcs_pkg.sv @@
`default_nettype none
package snfcs_pkg;

    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_WBYTE = 2'd2;

    localparam logic [2:0] OP_WREN   = 3'd0;
    localparam logic [2:0] OP_WRDI   = 3'd1;
    localparam logic [2:0] OP_WAIT   = 3'd2;
    localparam logic [2:0] OP_SERASE = 3'd3;
    localparam logic [2:0] OP_CERASE = 3'd4;
    localparam logic [2:0] OP_WRITE  = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;
    localparam logic [2:0] OP_RDID   = 3'd7;

    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_WRDI   = 8'h04;
    localparam logic [7:0] CMD_RDSR   = 8'h05;
    localparam logic [7:0] CMD_DUMMY  = 8'h11;
    localparam logic [7:0] CMD_SERASE = 8'h20;
    localparam logic [7:0] CMD_CERASE = 8'hC7;
    localparam logic [7:0] CMD_PROG   = 8'h02;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_RDID   = 8'h9F;

    localparam logic [1:0] AP_DONE  = 2'd0;
    localparam logic [1:0] AP_FIRST = 2'd1;
    localparam logic [1:0] AP_FINAL = 2'd2;

    typedef enum logic [12:0] {
        PH_IDLE       = 13'h0001,
        PH_SINGLE     = 13'h0002,
        PH_WREN       = 13'h0004,
        PH_POLL_CMD   = 13'h0008,
        PH_POLL_DUMMY = 13'h0010,
        PH_POLL_REL   = 13'h0020,
        PH_CMD        = 13'h0040,
        PH_ADDR       = 13'h0080,
        PH_DATA_REQ   = 13'h0100,
        PH_DATA_TX    = 13'h0200,
        PH_RD_DATA    = 13'h0400,
        PH_ID_CMD     = 13'h0800,
        PH_ID_DATA    = 13'h1000
    } phase_t;

    // result beat, highest tdata field first
    typedef struct packed {
        logic        rejected;
        logic        done_res;
        logic [23:0] id_value;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        data_request;
        logic        cs_release;
        logic [7:0]  mosi_byte;
        logic        spi_valid;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/spi_nor_flash_command_sequencer.sv @@
// SPI NOR flash command sequencer.
// Slave channel (s_): one beat is a host request (kind 0), a finished SPI byte
// exchange with the returned byte (kind 1) or a write data byte (kind 2).
// Master channel (m_): zero or one result beat per input beat; a result tells
// the SPI engine which byte to send and when to raise chip select, asks for
// write data, returns read data / ID, or flags done or a rejected request.
// Every input beat is decided in its own cycle by the sequencer and the result
// lands in a single output register; throughput is one beat per cycle. The
// input is taken whenever the output register is empty or is being drained in
// the same cycle, so a stalled receiver holds the result and back-pressures
// the slave side only while that register stays full. Reset (aresetn low,
// synchronous) returns the sequencer to idle and empties the output register.
// Erase and program run write enable, a status poll, the command (with address
// except for chip erase), then a second poll; writes split at page ends.
`default_nettype none
module spi_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES   = 256,
    parameter int ADDRESS_BITS = 24
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: op[2:0], address[26:3], length[50:27], miso_byte[58:51],
    //        write_byte[66:59], zero fill to 72
    input  wire  [71:0] s_tdata,
    // tuser: kind[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: spi_valid[0], mosi_byte[8:1], cs_release[9], data_request[10],
    //        read_valid[11], read_byte[19:12], id_value[43:20], done_res[44],
    //        rejected[45], zero fill to 48
    output logic [47:0] m_tdata
);
    import snfcs_pkg::*;

    localparam int AW = (ADDRESS_BITS < 24) ? ADDRESS_BITS : 24;
    localparam int PB = $clog2(PAGE_BYTES);
    localparam int CW = PB + 1;

    phase_t      phase_reg, phase_next;
    logic [2:0]  op_reg, op_next;
    logic [23:0] addr_reg, addr_next;
    logic [23:0] left_reg, left_next;
    logic [CW-1:0] chunk_reg, chunk_next;
    logic [1:0]  idx_reg, idx_next;
    logic [23:0] id_reg, id_next;
    logic [1:0]  ap_reg, ap_next;
    logic        ov_reg;
    result_t     res_reg, res;
    logic        have;

    logic        acc;
    logic [1:0]  kind;
    logic [2:0]  in_op;
    logic [23:0] in_addr, in_len;
    logic [7:0]  miso, wbyte;
    logic [23:0] amask;
    logic [CW-1:0] room;
    logic [CW-1:0] chunk_calc;
    logic [23:0] nleft;
    logic [23:0] id_sh;

    assign kind    = s_tuser;
    assign in_op   = s_tdata[2:0];
    assign in_addr = s_tdata[26:3];
    assign in_len  = s_tdata[50:27];
    assign miso    = s_tdata[58:51];
    assign wbyte   = s_tdata[66:59];
    assign amask   = 24'((25'd1 << AW) - 25'd1);

    assign s_tready = !ov_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, res_reg};

    // page room from the current address, used when a chunk starts
    assign room = CW'(PAGE_BYTES) - {1'b0, addr_reg[PB-1:0]};
    assign chunk_calc = (left_reg < 24'(room)) ? CW'(left_reg) : room;
    assign nleft = left_reg - 24'd1;
    assign id_sh = {id_reg[15:0], miso};

    // decide one beat
    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        idx_next   = idx_reg;
        id_next    = id_reg;
        ap_next    = ap_reg;
        res        = '0;
        have       = 1'b0;
        unique case (kind)
            KIND_REQ: begin
                if (phase_reg != PH_IDLE) begin
                    res.rejected = 1'b1;
                    have = 1'b1;
                end else begin
                    op_next    = in_op;
                    addr_next  = in_addr & amask;
                    left_next  = in_len;
                    chunk_next = '0;
                    idx_next   = '0;
                    have       = 1'b1;
                    res.spi_valid = 1'b1;
                    unique case (in_op)
                        OP_WREN: begin
                            res.mosi_byte = CMD_WREN; res.cs_release = 1'b1;
                            phase_next = PH_SINGLE;
                        end
                        OP_WRDI: begin
                            res.mosi_byte = CMD_WRDI; res.cs_release = 1'b1;
                            phase_next = PH_SINGLE;
                        end
                        OP_WAIT: begin
                            res.mosi_byte = CMD_RDSR; phase_next = PH_POLL_CMD;
                            ap_next = AP_DONE;
                        end
                        OP_RDID: begin
                            id_next = '0; res.mosi_byte = CMD_RDID;
                            phase_next = PH_ID_CMD;
                        end
                        default: begin
                            // write: first chunk from the request address
                            if (in_op == OP_WRITE) begin
                                chunk_next = ((in_len < 24'(CW'(PAGE_BYTES)
                                    - {1'b0, in_addr[PB-1:0]})) ? CW'(in_len)
                                    : (CW'(PAGE_BYTES) - {1'b0, in_addr[PB-1:0]}));
                            end
                            res.mosi_byte = CMD_WREN; res.cs_release = 1'b1;
                            phase_next = PH_WREN; ap_next = AP_FIRST;
                        end
                    endcase
                end
            end
            KIND_WBYTE: begin
                if (phase_reg == PH_DATA_REQ) begin
                    have = 1'b1;
                    res.spi_valid = 1'b1; res.mosi_byte = wbyte;
                    res.cs_release = (chunk_reg == CW'(1));
                    phase_next = PH_DATA_TX;
                end
            end
            KIND_DONE: begin
                have = 1'b1;
                unique case (phase_reg)
                    PH_SINGLE: begin
                        res.done_res = 1'b1; phase_next = PH_IDLE;
                    end
                    PH_WREN: begin
                        res.spi_valid = 1'b1; res.mosi_byte = CMD_RDSR;
                        phase_next = PH_POLL_CMD;
                    end
                    PH_POLL_CMD: begin
                        res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                        phase_next = PH_POLL_DUMMY;
                    end
                    PH_POLL_DUMMY: begin
                        if (miso[0]) begin
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                        end else begin
                            res.cs_release = 1'b1; phase_next = PH_POLL_REL;
                        end
                    end
                    PH_POLL_REL: begin
                        priority if (ap_reg == AP_FIRST) begin
                            res.spi_valid = 1'b1;
                            priority case (op_reg)
                                OP_SERASE: res.mosi_byte = CMD_SERASE;
                                OP_CERASE: res.mosi_byte = CMD_CERASE;
                                OP_WRITE:  res.mosi_byte = CMD_PROG;
                                default:   res.mosi_byte = CMD_READ;
                            endcase
                            res.cs_release = (op_reg == OP_CERASE);
                            phase_next = PH_CMD;
                        end else if (ap_reg == AP_FINAL && op_reg == OP_WRITE
                                     && left_reg != '0) begin
                            chunk_next = chunk_calc;
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_WREN;
                            res.cs_release = 1'b1;
                            phase_next = PH_WREN; ap_next = AP_FIRST;
                        end else begin
                            res.done_res = 1'b1; phase_next = PH_IDLE;
                        end
                    end
                    PH_CMD: begin
                        res.spi_valid = 1'b1;
                        if (op_reg == OP_CERASE) begin
                            res.mosi_byte = CMD_RDSR; phase_next = PH_POLL_CMD;
                            ap_next = AP_FINAL;
                        end else begin
                            res.mosi_byte = addr_reg[23:16]; idx_next = 2'd1;
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        priority if (idx_reg == 2'd1) begin
                            res.spi_valid = 1'b1; res.mosi_byte = addr_reg[15:8];
                            idx_next = 2'd2;
                        end else if (idx_reg == 2'd2) begin
                            res.spi_valid = 1'b1; res.mosi_byte = addr_reg[7:0];
                            res.cs_release = (op_reg == OP_SERASE)
                                || (op_reg == OP_WRITE && chunk_reg == '0)
                                || (op_reg == OP_READ && left_reg == '0);
                            idx_next = 2'd3;
                        end else if (op_reg == OP_SERASE
                                     || (op_reg == OP_WRITE && chunk_reg == '0)) begin
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_RDSR;
                            phase_next = PH_POLL_CMD; ap_next = AP_FINAL;
                        end else if (op_reg == OP_WRITE) begin
                            res.data_request = 1'b1; phase_next = PH_DATA_REQ;
                        end else if (left_reg != '0) begin
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                            res.cs_release = (left_reg == 24'd1);
                            phase_next = PH_RD_DATA;
                        end else begin
                            res.done_res = 1'b1; phase_next = PH_IDLE;
                        end
                    end
                    PH_DATA_TX: begin
                        chunk_next = chunk_reg - CW'(1);
                        left_next  = nleft;
                        addr_next  = (addr_reg + 24'd1) & amask;
                        if (chunk_reg != CW'(1)) begin
                            res.data_request = 1'b1; phase_next = PH_DATA_REQ;
                        end else begin
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_RDSR;
                            phase_next = PH_POLL_CMD; ap_next = AP_FINAL;
                        end
                    end
                    PH_RD_DATA: begin
                        res.read_valid = 1'b1; res.read_byte = miso;
                        left_next = nleft;
                        if (nleft == '0) begin
                            res.done_res = 1'b1; phase_next = PH_IDLE;
                        end else begin
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                            res.cs_release = (nleft == 24'd1);
                        end
                    end
                    PH_ID_CMD: begin
                        res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                        idx_next = '0; phase_next = PH_ID_DATA;
                    end
                    PH_ID_DATA: begin
                        id_next = id_sh;
                        if (idx_reg == 2'd2) begin
                            res.id_value = id_sh; res.done_res = 1'b1;
                            phase_next = PH_IDLE; idx_next = '0;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                            res.spi_valid = 1'b1; res.mosi_byte = CMD_DUMMY;
                            res.cs_release = (idx_reg == 2'd1);
                        end
                    end
                    default: have = 1'b0;
                endcase
            end
            default: have = 1'b0;
        endcase
    end

    // advance state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            op_reg    <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            idx_reg   <= '0;
            id_reg    <= '0;
            ap_reg    <= AP_DONE;
            ov_reg    <= 1'b0;
        end else begin
            if (acc) begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                addr_reg  <= addr_next;
                left_reg  <= left_next;
                chunk_reg <= chunk_next;
                idx_reg   <= idx_next;
                id_reg    <= id_next;
                ap_reg    <= ap_next;
                ov_reg    <= have;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // hold payload
    always_ff @(posedge aclk) begin
        if (acc && have) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire
